// ===== rtl/rgblut_pkg.sv =====
package rgblut_pkg;

    localparam int COMP_W          = 8;
    localparam int STEP_W          = 16;
    localparam int VAL_W           = 16;
    localparam int FRAC_W          = 12;
    localparam int POS_W           = COMP_W + STEP_W;
    localparam int IDX_W           = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int DEF_TABLE_DEPTH = 256;
    // result queue depth, also the number of map items allowed in flight
    localparam int FIFO_DEPTH      = 8;

    typedef enum logic
    {
        OP_MAP   = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_RED_OFFSET   = 3'd0,
        REG_GREEN_OFFSET = 3'd1,
        REG_BLUE_OFFSET  = 3'd2,
        REG_RED_STEP     = 3'd3,
        REG_GREEN_STEP   = 3'd4,
        REG_BLUE_STEP    = 3'd5
    } reg_idx_t;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd4096;

    typedef struct packed
    {
        logic [COMP_W-1:0] offset;
        logic [STEP_W-1:0] step;
    } chan_cfg_t;

    typedef struct packed
    {
        logic              valid;
        logic [COMP_W-1:0] level;
    } lane_out_t;

    typedef struct packed
    {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pixel_t;

endpackage

// ===== rtl/rgblut_ram.sv =====
module rgblut_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/rgblut_lane.sv =====
module rgblut_lane #(
    parameter int TABLE_DEPTH = rgblut_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              map_valid,
    input  logic [rgblut_pkg::COMP_W-1:0]     comp,
    input  rgblut_pkg::chan_cfg_t             cfg,
    input  logic                              wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
    input  logic signed [rgblut_pkg::VAL_W-1:0] wr_data,
    output rgblut_pkg::lane_out_t             result
);

    import rgblut_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int INT_W  = POS_W - FRAC_W;
    localparam int DELTA_W = VAL_W + 1;
    localparam int PROD_W = DELTA_W + FRAC_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    // stage 1: position
    logic [COMP_W:0]         diff;
    logic [POS_W-1:0]        pos_next;
    logic                    s1_valid_reg;
    logic [POS_W-1:0]        s1_pos_reg;
    logic                    s1_wr_reg;
    logic [AW-1:0]           s1_waddr_reg;
    logic [VAL_W-1:0]        s1_wdata_reg;

    // stage 2: table read
    logic [INT_W-1:0]        k;
    logic                    sat;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic [FRAC_W-1:0]       frac_next;
    logic                    s2_valid_reg;
    logic [FRAC_W-1:0]       s2_frac_reg;
    logic [VAL_W-1:0]        rd_a;
    logic [VAL_W-1:0]        rd_b;

    // stage 3: blend product
    logic signed [DELTA_W-1:0] delta;
    logic signed [PROD_W-1:0]  prod_next;
    logic                      s3_valid_reg;
    logic signed [VAL_W-1:0]   s3_a_reg;
    logic signed [PROD_W-1:0]  s3_prod_reg;
    logic signed [SUM_W-1:0]   blend;

    assign diff     = {1'b0, comp} - {1'b0, cfg.offset};
    // negative distance pins to entry 0
    assign pos_next = diff[COMP_W] ? '0
                    : POS_W'(diff[COMP_W-1:0]) * POS_W'(cfg.step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= map_valid;
            s1_wr_reg    <= wr_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg   <= pos_next;
        s1_waddr_reg <= wr_addr;
        s1_wdata_reg <= wr_data;
        s2_frac_reg  <= frac_next;
        s3_a_reg     <= $signed(rd_a);
        s3_prod_reg  <= prod_next;
    end

    assign k         = s1_pos_reg[POS_W-1:FRAC_W];
    assign sat       = (k >= INT_W'(TABLE_DEPTH - 1));
    assign addr_a    = sat ? AW'(TABLE_DEPTH - 1) : k[AW-1:0];
    assign frac_next = sat ? '0 : s1_pos_reg[FRAC_W-1:0];
    // zero fraction reads the same entry twice, so the top entry never overruns
    assign addr_b    = (frac_next != '0) ? addr_a + AW'(1) : addr_a;

    // writes land in the same stage that issues reads, keeping item order
    rgblut_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (s1_wr_reg),
        .waddr   (s1_waddr_reg),
        .wdata   (s1_wdata_reg),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign delta     = DELTA_W'($signed(rd_b)) - DELTA_W'($signed(rd_a));
    assign prod_next = delta * $signed({1'b0, s2_frac_reg});

    assign blend = (SUM_W'(s3_a_reg) <<< FRAC_W) + SUM_W'(s3_prod_reg);

    always_comb
    begin
        result.valid = s3_valid_reg;
        if (blend[SUM_W-1])
        begin
            result.level = '0;
        end
        else if (|blend[SUM_W-2:COMP_W+FRAC_W+8])
        begin
            result.level = '1;
        end
        else
        begin
            result.level = blend[COMP_W+FRAC_W+7:FRAC_W+8];
        end
    end

endmodule

// ===== rtl/rgblut_merge.sv =====
module rgblut_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          map_accept,
    input  rgblut_pkg::lane_out_t         red_res,
    input  rgblut_pkg::lane_out_t         green_res,
    input  rgblut_pkg::lane_out_t         blue_res,
    output logic                          full,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [rgblut_pkg::COMP_W-1:0] red_out,
    output logic [rgblut_pkg::COMP_W-1:0] green_out,
    output logic [rgblut_pkg::COMP_W-1:0] blue_out
);

    import rgblut_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH) + 1;

    pixel_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   credit_reg;
    logic [PTR_W-1:0]   credit_next;
    logic               push;
    logic               pop;
    pixel_t             head;

    assign push = red_res.valid & green_res.valid & blue_res.valid;
    assign pop  = res_valid & ~res_stall;

    always_comb
    begin
        case ({map_accept, pop})
            2'b10:   credit_next = credit_reg + PTR_W'(1);
            2'b01:   credit_next = credit_reg - PTR_W'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg[PTR_W-2:0]] <= '{red:   red_res.level,
                                            green: green_res.level,
                                            blue:  blue_res.level};
        end
    end

    // credits count map items from acceptance until their result is taken
    assign full      = (credit_reg == PTR_W'(FIFO_DEPTH));
    assign res_valid = (wr_ptr_reg != rd_ptr_reg);
    assign head      = mem[rd_ptr_reg[PTR_W-2:0]];
    assign red_out   = head.red;
    assign green_out = head.green;
    assign blue_out  = head.blue;

endmodule

// ===== rtl/rgb_1d_lut_interpolator.sv =====
// RGB 1D LUT interpolator. Each pixel component runs through its own lane:
// position = (component - offset) * step (u4.12), saturated to the table
// ends; the two neighboring s8.8 entries are blended by the 12-bit fraction,
// and the integer part is clamped to 0..255. One item (pixel or table write)
// is taken per clock while pix_stall is low; a pixel's result goes through the
// lane pipeline (position multiply, table read, blend multiply, add and clamp),
// and results queue in an 8-entry FIFO; pix_stall rises only when 8 pixels are
// in flight or waiting, so a stalled output does not hold the input until that
// queue is used up. A table write with channel 3 or an index at or past
// TABLE_DEPTH is dropped. Table contents are undefined until written; read
// only entries that were loaded. Registers are written on cfg_valid
// (cfg_ready is always high) and should change only while idle.
module rgb_1d_lut_interpolator #(
    parameter int TABLE_DEPTH = rgblut_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // pixel / table write channel
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  logic                              operation,
    input  logic [rgblut_pkg::COMP_W-1:0]     red_in,
    input  logic [rgblut_pkg::COMP_W-1:0]     green_in,
    input  logic [rgblut_pkg::COMP_W-1:0]     blue_in,
    input  logic [1:0]                        table_channel,
    input  logic [rgblut_pkg::IDX_W-1:0]      table_index,
    input  logic signed [rgblut_pkg::VAL_W-1:0] table_value,

    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [rgblut_pkg::COMP_W-1:0]     red_out,
    output logic [rgblut_pkg::COMP_W-1:0]     green_out,
    output logic [rgblut_pkg::COMP_W-1:0]     blue_out,

    // register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgblut_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgblut_pkg::CFG_DATA_W-1:0] cfg_data
);

    import rgblut_pkg::*;

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int IDX_EXT_W = AW + IDX_W;

    chan_cfg_t          red_cfg_reg;
    chan_cfg_t          green_cfg_reg;
    chan_cfg_t          blue_cfg_reg;

    logic               accept;
    logic               map_accept;
    logic               wr_ok;
    logic               wr_red;
    logic               wr_green;
    logic               wr_blue;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [AW-1:0]      wr_addr;

    lane_out_t          red_res;
    lane_out_t          green_res;
    lane_out_t          blue_res;
    logic               full;

    assign cfg_ready = 1'b1;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cfg_reg   <= '{offset: '0, step: STEP_RESET};
            green_cfg_reg <= '{offset: '0, step: STEP_RESET};
            blue_cfg_reg  <= '{offset: '0, step: STEP_RESET};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RED_OFFSET:   red_cfg_reg.offset   <= cfg_data[COMP_W-1:0];
                REG_GREEN_OFFSET: green_cfg_reg.offset <= cfg_data[COMP_W-1:0];
                REG_BLUE_OFFSET:  blue_cfg_reg.offset  <= cfg_data[COMP_W-1:0];
                REG_RED_STEP:     red_cfg_reg.step     <= cfg_data[STEP_W-1:0];
                REG_GREEN_STEP:   green_cfg_reg.step   <= cfg_data[STEP_W-1:0];
                REG_BLUE_STEP:    blue_cfg_reg.step    <= cfg_data[STEP_W-1:0];
                default:          ; // unknown index: no register
            endcase
        end
    end

    // ---------------- input transfer decode ----------------
    assign pix_stall  = full;
    assign accept     = pix_valid & ~pix_stall;
    assign map_accept = accept & (operation == OP_MAP);

    // index must land inside the table
    assign idx_ext  = IDX_EXT_W'(table_index);
    assign wr_addr  = idx_ext[AW-1:0];
    assign wr_ok    = accept & (operation == OP_WRITE)
                    & (32'(table_index) < 32'(TABLE_DEPTH));
    assign wr_red   = wr_ok & (table_channel == CH_RED);
    assign wr_green = wr_ok & (table_channel == CH_GREEN);
    assign wr_blue  = wr_ok & (table_channel == CH_BLUE);

    // ---------------- one lane per color component ----------------
    rgblut_lane #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lane_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_valid (map_accept),
        .comp      (red_in),
        .cfg       (red_cfg_reg),
        .wr_en     (wr_red),
        .wr_addr   (wr_addr),
        .wr_data   (table_value),
        .result    (red_res)
    );

    rgblut_lane #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lane_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_valid (map_accept),
        .comp      (green_in),
        .cfg       (green_cfg_reg),
        .wr_en     (wr_green),
        .wr_addr   (wr_addr),
        .wr_data   (table_value),
        .result    (green_res)
    );

    rgblut_lane #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lane_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_valid (map_accept),
        .comp      (blue_in),
        .cfg       (blue_cfg_reg),
        .wr_en     (wr_blue),
        .wr_addr   (wr_addr),
        .wr_data   (table_value),
        .result    (blue_res)
    );

    // ---------------- merge lanes into the result queue ----------------
    rgblut_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .map_accept (map_accept),
        .red_res    (red_res),
        .green_res  (green_res),
        .blue_res   (blue_res),
        .full       (full),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out)
    );

endmodule

// ===== sim/rgb_lut_checker.sv =====
module rgb_lut_checker
    import rgblut_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pix_valid,
    input  logic                     pix_stall,
    input  logic                     operation,
    input  logic [COMP_W-1:0]        red_in,
    input  logic [COMP_W-1:0]        green_in,
    input  logic [COMP_W-1:0]        blue_in,
    input  logic [1:0]               table_channel,
    input  logic [IDX_W-1:0]         table_index,
    input  logic signed [VAL_W-1:0]  table_value,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  logic [COMP_W-1:0]        red_out,
    input  logic [COMP_W-1:0]        green_out,
    input  logic [COMP_W-1:0]        blue_out,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       pending,
    output int                       failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH     = 3;
    localparam int PRINT_CAP  = 40;

    typedef struct {
        pixel_t src;
        pixel_t want;
    } level_due_t;

    logic signed [VAL_W-1:0] lut [NUM_CH][TABLE_DEPTH];
    logic [COMP_W-1:0]       ofs [NUM_CH];
    logic [STEP_W-1:0]       stp [NUM_CH];
    level_due_t              levels_due [$];
    int                      n_fail = 0;

    task automatic report_mismatch(string msg);
        if (n_fail < PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
        n_fail++;
    endtask

    // position = (comp - offset) * step, 12 fraction bits, saturated at both ends
    function automatic logic [COMP_W-1:0] interp_level(logic [COMP_W-1:0] comp, chan_t ch);
        longint pos;
        longint k;
        longint frac;
        longint a;
        longint b;
        longint v;
        pos = (longint'(comp) - longint'(ofs[ch])) * longint'(stp[ch]);
        if (pos < 0)
        begin
            k = 0;
            frac = 0;
        end
        else
        begin
            k = pos >>> FRAC_W;
            frac = pos & ((longint'(1) << FRAC_W) - 1);
            if (k >= TABLE_DEPTH - 1)
            begin
                k = TABLE_DEPTH - 1;
                frac = 0;
            end
        end
        a = lut[ch][k];
        if (frac != 0)
            b = lut[ch][k + 1];
        else
            b = a;
        v = (a << FRAC_W) + (b - a) * frac;
        if (v < 0)
            return '0;
        v = v >>> (FRAC_W + 8);
        if (v > 255)
            v = 255;
        return v[COMP_W-1:0];
    endfunction

    task automatic check_level(string name, logic [COMP_W-1:0] got, logic [COMP_W-1:0] want,
                               pixel_t src);
        if (got !== want)
            report_mismatch($sformatf("%s = %0d, predicted %0d (pixel %0d,%0d,%0d)",
                                      name, got, want, src.red, src.green, src.blue));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs = '{default: '0};
            stp = '{default: STEP_RESET};
            levels_due.delete();
            pending  <= 0;
            failures <= n_fail;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RED_OFFSET:   ofs[CH_RED]   = cfg_data[COMP_W-1:0];
                    REG_GREEN_OFFSET: ofs[CH_GREEN] = cfg_data[COMP_W-1:0];
                    REG_BLUE_OFFSET:  ofs[CH_BLUE]  = cfg_data[COMP_W-1:0];
                    REG_RED_STEP:     stp[CH_RED]   = cfg_data[STEP_W-1:0];
                    REG_GREEN_STEP:   stp[CH_GREEN] = cfg_data[STEP_W-1:0];
                    REG_BLUE_STEP:    stp[CH_BLUE]  = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (pix_valid && !pix_stall)
            begin
                if (operation == OP_WRITE)
                begin
                    case (table_channel)
                        CH_RED, CH_GREEN, CH_BLUE:
                            if (int'(table_index) < TABLE_DEPTH)
                                lut[table_channel][table_index] = table_value;
                        default: ;
                    endcase
                end
                else
                begin
                    level_due_t d;
                    d.src  = '{red: red_in, green: green_in, blue: blue_in};
                    d.want = '{red:   interp_level(red_in, CH_RED),
                               green: interp_level(green_in, CH_GREEN),
                               blue:  interp_level(blue_in, CH_BLUE)};
                    levels_due.push_back(d);
                end
            end

            if (res_valid && !res_stall)
            begin
                if (levels_due.size() == 0)
                    report_mismatch($sformatf("result %0d,%0d,%0d with no pixel in flight",
                                              red_out, green_out, blue_out));
                else
                begin
                    level_due_t d;
                    d = levels_due.pop_front();
                    check_level("red_out",   red_out,   d.want.red,   d.src);
                    check_level("green_out", green_out, d.want.green, d.src);
                    check_level("blue_out",  blue_out,  d.want.blue,  d.src);
                end
            end

            pending  <= levels_due.size();
            failures <= n_fail;
        end
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    import rgblut_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = DEF_TABLE_DEPTH;
    localparam int NUM_REGS        = 6;
    // a table write gives no result to wait for, so allow a margin past the pipeline depth
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int PRESSURE_PHASE  = 2;

    // indexes past the last register and the table selector past blue: both ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [1:0]           CH_NONE     = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     pix_valid;
    logic                     pix_stall;
    logic                     operation;
    logic [COMP_W-1:0]        red_in;
    logic [COMP_W-1:0]        green_in;
    logic [COMP_W-1:0]        blue_in;
    logic [1:0]               table_channel;
    logic [IDX_W-1:0]         table_index;
    logic signed [VAL_W-1:0]  table_value;
    logic                     res_valid;
    logic                     res_stall;
    logic [COMP_W-1:0]        red_out;
    logic [COMP_W-1:0]        green_out;
    logic [COMP_W-1:0]        blue_out;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    int                       pending;
    int                       failures;

    // per-phase idle rates (percent chance of an idle burst per item / of a stall burst per cycle)
    int                       tx_gap_pct   = 0;
    int                       rx_stall_pct = 0;
    bit                       hold_off_req = 0;
    int                       quiet_cycles = 0;

    logic [CFG_DATA_W-1:0]    reg_val [NUM_REGS];
    int                       n_maps     = 0;
    int                       n_loads    = 0;
    int                       n_settings = 0;

    int tx_gap_by_phase [RAND_PHASES] = '{20, 0, 0, 40, 10, 30, 15, 0};
    int rx_gap_by_phase [RAND_PHASES] = '{20, 40, 0, 0, 30, 10, 50, 0};

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    rgb_1d_lut_interpolator #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    rgb_lut_checker #(.TABLE_DEPTH(DEPTH)) lut_check (.*);

    // Watchdog: any transfer on any channel resets the count. The longest legal
    // quiet stretch is the output hold-off, well under the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results still due",
                     quiet_cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side. A requested hold-off takes priority over the random bursts;
    // it keeps stall high long enough for the 8-deep result queue to fill and
    // push back on the input.
    initial
    begin
        res_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 0;
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.red   = COMP_W'($urandom);
        p.green = COMP_W'($urandom);
        p.blue  = COMP_W'($urandom);
        return p;
    endfunction

    // Mostly a rising ramp near the index (outputs land in the lower half of the range and
    // move with the fraction), a quarter full-range values that hit the negative clamp.
    function automatic logic signed [VAL_W-1:0] table_level(int idx);
        int v;
        if ($urandom_range(0, 3) == 0)
            return VAL_W'($urandom);
        v = idx * 128 + int'($urandom_range(0, 255)) - 128;
        return VAL_W'(v);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return STEP_RESET;
            3: return STEP_W'($urandom);
            default: return STEP_W'($urandom_range(16'h0040, 16'h1100));
        endcase
    endfunction

    function automatic logic [COMP_W-1:0] pick_offset();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return COMP_W'($urandom);
            default: return COMP_W'($urandom_range(0, 64));
        endcase
    endfunction

    // One transfer on the pixel channel. Valid is dropped only for a gap burst,
    // otherwise it stays high from one transfer into the next.
    task automatic offer(op_t op, pixel_t px, logic [1:0] ch, logic [IDX_W-1:0] idx,
                         logic signed [VAL_W-1:0] val);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        pix_valid     <= 1'b1;
        operation     <= op;
        red_in        <= px.red;
        green_in      <= px.green;
        blue_in       <= px.blue;
        table_channel <= ch;
        table_index   <= idx;
        table_value   <= val;
        do
            @(posedge clk);
        while (pix_stall);
    endtask

    // table fields of a map transfer carry junk; the block must ignore them
    task automatic map_pixel(pixel_t px);
        offer(OP_MAP, px, 2'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        n_maps++;
    endtask

    task automatic load_entry(logic [1:0] ch, logic [IDX_W-1:0] idx,
                              logic signed [VAL_W-1:0] val);
        offer(OP_WRITE, rand_pixel(), ch, idx, val);
        if (ch != CH_NONE)
            n_loads++;
    endtask

    // Wait until every predicted result has come back, then let any trailing
    // table write clear the pipeline before registers change. The first edge
    // lets the count take in the transfer that was just made.
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all six registers from reg_val, then one ignored spare index.
    // cfg_valid stays high across the burst and drops once at the end.
    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= reg_val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        cfg_data  <= CFG_DATA_W'($urandom);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // offset registers get junk in their upper byte, which must be dropped
    task automatic set_lanes(logic [COMP_W-1:0] r_ofs, logic [COMP_W-1:0] g_ofs,
                             logic [COMP_W-1:0] b_ofs, logic [STEP_W-1:0] r_stp,
                             logic [STEP_W-1:0] g_stp, logic [STEP_W-1:0] b_stp);
        settle();
        reg_val[REG_RED_OFFSET]   = {COMP_W'($urandom), r_ofs};
        reg_val[REG_GREEN_OFFSET] = {COMP_W'($urandom), g_ofs};
        reg_val[REG_BLUE_OFFSET]  = {COMP_W'($urandom), b_ofs};
        reg_val[REG_RED_STEP]     = r_stp;
        reg_val[REG_GREEN_STEP]   = g_stp;
        reg_val[REG_BLUE_STEP]    = b_stp;
        program_regs();
    endtask

    initial
    begin
        int done;
        int pick;

        // every input known from time zero
        rst_n         <= 1'b0;
        pix_valid     <= 1'b0;
        operation     <= OP_MAP;
        red_in        <= '0;
        green_in      <= '0;
        blue_in       <= '0;
        table_channel <= CH_RED;
        table_index   <= '0;
        table_value   <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_RED_OFFSET;
        cfg_data      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Preload every entry of every table so no pixel can ever touch an
        // unwritten entry. Extremes of the entry value are planted at the red and green ends.
        tx_gap_pct   = 15;
        rx_stall_pct = 20;
        for (int c = CH_RED; c <= CH_BLUE; c++)
        begin
            for (int i = 0; i < DEPTH; i++)
                load_entry(2'(c), IDX_W'(i), table_level(i));
        end
        load_entry(CH_RED, '1, 16'sh7FFF);
        load_entry(CH_GREEN, '0, -16'sh8000);
        load_entry(CH_BLUE, 8'd1, -16'sh0001);
        load_entry(CH_NONE, '1, 16'sh1234);

        // Directed, reset settings: offset 0, unit step, so entry = component.
        map_pixel('{red: 8'd0,   green: 8'd0,   blue: 8'd0});
        map_pixel('{red: 8'd255, green: 8'd255, blue: 8'd255});
        map_pixel('{red: 8'd1,   green: 8'd128, blue: 8'd254});
        map_pixel('{red: 8'h55,  green: 8'hAA,  blue: 8'h7F});

        // Red: max step, saturates at the last entry from component 16 on.
        // Green: components below the offset give a negative position.
        // Blue: zero step always lands on entry 0.
        set_lanes(8'd0, 8'd128, 8'd255, '1, STEP_RESET, '0);
        map_pixel('{red: 8'd0,   green: 8'd0,   blue: 8'd0});
        map_pixel('{red: 8'd16,  green: 8'd127, blue: 8'd255});
        map_pixel('{red: 8'd17,  green: 8'd128, blue: 8'd9});
        map_pixel('{red: 8'd255, green: 8'd255, blue: 8'd200});
        map_pixel('{red: 8'd200, green: 8'd129, blue: 8'd1});

        // Fractional steps: blends between neighbors, blue saturates at the top.
        set_lanes(8'd0, 8'd3, 8'd10, 16'h0800, 16'h0155, 16'h1FFF);
        map_pixel('{red: 8'd1,   green: 8'd4,   blue: 8'd11});
        map_pixel('{red: 8'd255, green: 8'd255, blue: 8'd255});
        map_pixel('{red: 8'd77,  green: 8'd130, blue: 8'd40});
        map_pixel('{red: 8'd254, green: 8'd200, blue: 8'd137});
        // a fresh write must be seen by the very next pixel
        load_entry(CH_RED, 8'h40, 16'sh7FFF);
        map_pixel('{red: 8'h80,  green: 8'd0,   blue: 8'd0});

        // Random phases, each under its own register setting and idle mix.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_lanes(pick_offset(), pick_offset(), pick_offset(),
                      pick_step(), pick_step(), pick_step());
            tx_gap_pct   = tx_gap_by_phase[ph];
            rx_stall_pct = rx_gap_by_phase[ph];
            if (ph == PRESSURE_PHASE)
                hold_off_req = 1;
            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    load_entry(CH_NONE, IDX_W'($urandom), VAL_W'($urandom));
                else if (pick < 18)
                begin
                    load_entry(2'($urandom_range(CH_RED, CH_BLUE)), IDX_W'($urandom),
                               table_level($urandom_range(0, DEPTH - 1)));
                    done++;
                end
                else
                begin
                    map_pixel(rand_pixel());
                    done++;
                end
            end
        end

        settle();

        $display("Covered %0d pixel maps and %0d table loads over %0d register settings,",
                 n_maps, n_loads, n_settings);
        $display("incl. both table-end saturations, zero step, negative clamp and a %0d-cycle "
                 , HOLD_OFF_CYCLES, "output hold-off.");
        if (failures == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
